// File: src/dscpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSCP marker package
// Shared opcodes, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package dscpm_pkg;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_WRITE  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_MODE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SCAN,
    ST_FINISH,
    ST_OUT
  } state_t;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic do_write;
    logic classify;
    logic scan_start;
    logic scan_step;
    logic finish;
    logic out_load;
  } dscpm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_packet;
    logic need_scan;
    logic scan_last;
  } dscpm_stat_t;

endpackage

// File: src/dscpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSCP marker controller
// Sequences capture, classification, the prefix scan and result delivery.
// ----------------------------------------------------------------------------
module dscpm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dscpm_pkg::dscpm_cmd_t cmd,
  input  dscpm_pkg::dscpm_stat_t stat
);

  dscpm_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dscpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      dscpm_pkg::ST_IDLE: begin
        if (in_valid) state_next = dscpm_pkg::ST_CLASSIFY;
      end
      dscpm_pkg::ST_CLASSIFY: begin
        if (!stat.is_packet) state_next = dscpm_pkg::ST_FINISH;
        else if (stat.need_scan) state_next = dscpm_pkg::ST_SCAN;
        else state_next = dscpm_pkg::ST_FINISH;
      end
      dscpm_pkg::ST_SCAN: begin
        if (stat.scan_last) state_next = dscpm_pkg::ST_FINISH;
      end
      dscpm_pkg::ST_FINISH: state_next = dscpm_pkg::ST_OUT;
      dscpm_pkg::ST_OUT: begin
        if (!out_stall) state_next = dscpm_pkg::ST_IDLE;
      end
      default: state_next = dscpm_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      dscpm_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      dscpm_pkg::ST_CLASSIFY: begin
        cmd.classify   = 1'b1;
        cmd.do_write   = !stat.is_packet;
        cmd.scan_start = stat.is_packet && stat.need_scan;
      end
      dscpm_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      dscpm_pkg::ST_FINISH: begin
        cmd.finish   = 1'b1;
        cmd.out_load = 1'b1;
      end
      dscpm_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // An item is taken only from idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> state == dscpm_pkg::ST_IDLE)
    else $error("accept outside idle");
  // A result waiting on stall stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
  // The scan only starts from classification.
  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == dscpm_pkg::ST_SCAN) |-> $past(state) == dscpm_pkg::ST_CLASSIFY)
    else $error("bad scan entry");
`endif

endmodule

// File: src/dscpm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSCP marker datapath
// Holds the tables and counters, scans prefixes one slot per cycle.
// ----------------------------------------------------------------------------
module dscpm_dp #(
  parameter int ENTRIES    = 128,
  parameter int INTERFACES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dscpm_pkg::dscpm_cmd_t  cmd,
  output dscpm_pkg::dscpm_stat_t stat,
  input  logic [1:0]             opcode,
  input  logic [6:0]             index,
  input  logic [15:0]            frame_len,
  input  logic [15:0]            ethertype,
  input  logic [7:0]             ttl,
  input  logic [7:0]             tos,
  input  logic [15:0]            checksum,
  input  logic [31:0]            src_addr,
  input  logic [31:0]            dst_addr,
  input  logic                   fib_ok,
  input  logic [5:0]             prefix_len,
  input  logic [7:0]             write_value,
  output logic                   action,
  output logic                   recorded,
  output logic                   marked,
  output logic [7:0]             new_tos,
  output logic [15:0]            new_checksum,
  output logic [63:0]            packet_total,
  output logic [63:0]            byte_total
);

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IW = (INTERFACES > 1) ? $clog2(INTERFACES) : 1;

  // Captured transaction.
  logic [1:0]  op_q;
  logic [6:0]  idx_q;
  logic [15:0] flen_q, etype_q, csum_q;
  logic [7:0]  ttl_q, tos_q, wval_q;
  logic [31:0] src_q, dst_q;
  logic        fib_q;
  logic [5:0]  plen_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= opcode; idx_q <= index; flen_q <= frame_len; etype_q <= ethertype;
      ttl_q <= ttl; tos_q <= tos; csum_q <= checksum; src_q <= src_addr;
      dst_q <= dst_addr; fib_q <= fib_ok; plen_q <= prefix_len; wval_q <= write_value;
    end
  end

  function automatic logic [31:0] pmask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len != 6'd0) m = 32'hFFFF_FFFF << (6'd32 - len);
    return m;
  endfunction

  // Prefix table memory, valid bits in flip-flops.
  logic [5:0]  pt_len  [ENTRIES];
  logic [31:0] pt_addr [ENTRIES];
  logic [7:0]  pt_mark [ENTRIES];
  logic [ENTRIES-1:0] pt_valid;

  // Interface mode memory, valid bits in flip-flops so unwritten modes read as zero.
  logic [1:0]            mode_mem [INTERFACES];
  logic [INTERFACES-1:0] mode_vld;
  logic [1:0]            mode_rd;
  logic                  mode_rd_v;

  logic [EW-1:0] slot;
  logic [IW-1:0] if_slot_in, if_slot;
  assign slot       = EW'(idx_q);
  assign if_slot_in = IW'(index);
  assign if_slot    = IW'(idx_q);

  logic idx_in_ent, idx_in_if;
  assign idx_in_ent = 32'(idx_q) < ENTRIES;
  assign idx_in_if  = 32'(idx_q) < INTERFACES;

  always_ff @(posedge clk) begin
    if (cmd.do_write && op_q == dscpm_pkg::OP_WRITE && idx_in_ent && plen_q <= 6'd32) begin
      pt_len[slot]  <= plen_q;
      pt_addr[slot] <= dst_q & pmask(plen_q);
      pt_mark[slot] <= wval_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= '0;
    end else if (cmd.do_write && idx_in_ent) begin
      if (op_q == dscpm_pkg::OP_WRITE && plen_q <= 6'd32) pt_valid[slot] <= 1'b1;
      else if (op_q == dscpm_pkg::OP_REMOVE) pt_valid[slot] <= 1'b0;
    end
  end

  // Mode memory write, saturated at mode 3.
  always_ff @(posedge clk) begin
    if (cmd.do_write && op_q == dscpm_pkg::OP_MODE && idx_in_if) begin
      mode_mem[if_slot] <= (wval_q > 8'd3) ? 2'd3 : wval_q[1:0];
    end
  end

  // Mode valid bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_vld <= '0;
    end else if (cmd.do_write && op_q == dscpm_pkg::OP_MODE && idx_in_if) begin
      mode_vld[if_slot] <= 1'b1;
    end
  end

  // Interface mode read, registered together with the captured transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_rd   <= mode_mem[if_slot_in];
      mode_rd_v <= mode_vld[if_slot_in];
    end
  end

  // Classification.
  logic [1:0] mode;
  logic       is_drop, is_skip;
  assign mode    = (idx_in_if && mode_rd_v) ? mode_rd : 2'd0;
  assign is_drop = flen_q < dscpm_pkg::MIN_FRAME_LEN;
  assign is_skip = ttl_q <= 8'd1 || etype_q != dscpm_pkg::ETHERTYPE_IPV4 || mode == 2'd0;

  logic kind_drop, kind_count;
  logic [31:0] key;
  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      kind_drop  <= op_q == dscpm_pkg::OP_PACKET && is_drop;
      kind_count <= op_q == dscpm_pkg::OP_PACKET && !is_drop && !is_skip;
      key        <= (mode == 2'd1) ? dst_q : src_q;
    end
  end

  assign stat.is_packet = op_q == dscpm_pkg::OP_PACKET;
  assign stat.need_scan = !is_drop && !is_skip && fib_q && (mode == 2'd1 || mode == 2'd2);

  // Scan, one slot per cycle, registered read.
  logic [EW:0] scan_idx;
  logic        rd_v, hit;
  logic [5:0]  rd_len, best_len;
  logic [31:0] rd_addr;
  logic [7:0]  rd_mark, best_mark;
  assign stat.scan_last = rd_v && !cmd.scan_start && scan_idx == (EW+1)'(ENTRIES);

  always_ff @(posedge clk) begin
    rd_len  <= pt_len[scan_idx[EW-1:0]];
    rd_addr <= pt_addr[scan_idx[EW-1:0]];
    rd_mark <= pt_mark[scan_idx[EW-1:0]];
  end

  logic rd_ok;
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      scan_idx <= '0; rd_v <= 1'b0; rd_ok <= 1'b0; hit <= 1'b0;
      best_len <= '0; best_mark <= '0;
    end else if (cmd.scan_start || cmd.scan_step) begin
      if (scan_idx != (EW+1)'(ENTRIES)) begin
        rd_ok    <= pt_valid[scan_idx[EW-1:0]];
        scan_idx <= scan_idx + 1'b1;
      end else begin
        rd_ok <= 1'b0;
      end
      rd_v <= 1'b1;
      if (rd_v && rd_ok && (key & pmask(rd_len)) == rd_addr && (!hit || rd_len > best_len)) begin
        hit <= 1'b1; best_len <= rd_len; best_mark <= rd_mark;
      end
    end
  end

  // Incremental checksum update.
  logic [31:0] c0, c1, c2;
  assign c0 = 32'(csum_q) + 32'(tos_q);
  assign c1 = ((c0 + 32'd1) >> 16) != 32'd0 ? ((c0 + 32'd1) & 32'h0000_FFFF) : c0;
  assign c2 = c1 - 32'(best_mark);

  // Counters indexed by action.
  logic [63:0] pkt_cnt [2];
  logic [63:0] byt_cnt [2];
  logic        act;
  assign act = kind_drop;
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_cnt[0] <= '0; pkt_cnt[1] <= '0; byt_cnt[0] <= '0; byt_cnt[1] <= '0;
    end else if (cmd.finish && (kind_drop || kind_count)) begin
      pkt_cnt[act] <= pkt_cnt[act] + 64'd1;
      byt_cnt[act] <= byt_cnt[act] + 64'(flen_q);
    end
  end

  // Output register.
  logic do_mark;
  assign do_mark = kind_count && hit;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      action       <= kind_drop;
      recorded     <= kind_drop || kind_count;
      marked       <= do_mark;
      new_tos      <= !stat.is_packet ? 8'd0 : (do_mark ? best_mark : tos_q);
      new_checksum <= !stat.is_packet ? 16'd0 : (do_mark ? 16'(c2 + (c2 >> 16)) : csum_q);
      packet_total <= (kind_drop || kind_count) ? pkt_cnt[act] + 64'd1 : 64'd0;
      byte_total   <= (kind_drop || kind_count) ? byt_cnt[act] + 64'(flen_q) : 64'd0;
    end
  end

`ifndef SYNTHESIS
  // A mark never comes without a count.
  a_mark_rec: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.out_load) |-> (!marked || recorded))
    else $error("marked but not recorded");
  // Drops are never marked.
  a_drop_nomark: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.out_load) |-> !(action && marked))
    else $error("dropped packet marked");
  // The scan pointer never passes the table depth.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    scan_idx <= (EW+1)'(ENTRIES))
    else $error("scan pointer overrun");
`endif

endmodule

// File: src/ipv4_dscp_marker_lpm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 DSCP marker with longest prefix match
// Counts, drops and re-marks packet headers; writes load the tables.
// ----------------------------------------------------------------------------
// Table writes and unscanned packets pass from capture through the classify and
// finish states to the result. Scanned packets also pass the scan state, where the
// prefix table is read one slot per cycle through its single registered read port.
// One transaction is in flight at a time; the next is taken back in idle once the
// result has been accepted.
// Reset clears the prefix and interface valid bits and the counters.
module ipv4_dscp_marker_lpm #(
  parameter int ENTRIES    = 128,
  parameter int INTERFACES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [6:0]  index,
  input  logic [15:0] frame_len,
  input  logic [15:0] ethertype,
  input  logic [7:0]  ttl,
  input  logic [7:0]  tos,
  input  logic [15:0] checksum,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic        fib_ok,
  input  logic [5:0]  prefix_len,
  input  logic [7:0]  write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        action,
  output logic        recorded,
  output logic        marked,
  output logic [7:0]  new_tos,
  output logic [15:0] new_checksum,
  output logic [63:0] packet_total,
  output logic [63:0] byte_total
);

  dscpm_pkg::dscpm_cmd_t  cmd;
  dscpm_pkg::dscpm_stat_t stat;

  // Controller.
  dscpm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  // Datapath.
  dscpm_dp #(.ENTRIES(ENTRIES), .INTERFACES(INTERFACES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .opcode(opcode), .index(index), .frame_len(frame_len), .ethertype(ethertype),
    .ttl(ttl), .tos(tos), .checksum(checksum), .src_addr(src_addr),
    .dst_addr(dst_addr), .fib_ok(fib_ok), .prefix_len(prefix_len),
    .write_value(write_value), .action(action), .recorded(recorded),
    .marked(marked), .new_tos(new_tos), .new_checksum(new_checksum),
    .packet_total(packet_total), .byte_total(byte_total)
  );

endmodule

// File: tb/dscpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSCP marker checker
// Watches both channels, predicts each result from its own copy of the
// tables and counters, and compares the results in order.
// ----------------------------------------------------------------------------
module dscpm_checker #(
  parameter int ENTRIES    = 128,
  parameter int INTERFACES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [6:0]  index,
  input  logic [15:0] frame_len,
  input  logic [15:0] ethertype,
  input  logic [7:0]  ttl,
  input  logic [7:0]  tos,
  input  logic [15:0] checksum,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic        fib_ok,
  input  logic [5:0]  prefix_len,
  input  logic [7:0]  write_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        action,
  input  logic        recorded,
  input  logic        marked,
  input  logic [7:0]  new_tos,
  input  logic [15:0] new_checksum,
  input  logic [63:0] packet_total,
  input  logic [63:0] byte_total,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        action;
    logic        recorded;
    logic        marked;
    logic [7:0]  new_tos;
    logic [15:0] new_checksum;
    logic [63:0] packet_total;
    logic [63:0] byte_total;
  } verdict_t;

  typedef struct {
    logic        valid;
    logic [5:0]  plen;
    logic [31:0] addr;
    logic [7:0]  mark;
  } route_t;

  route_t      routes [ENTRIES];
  logic [1:0]  if_mode [INTERFACES];
  logic [63:0] pkt_cnt [2];
  logic [63:0] byt_cnt [2];
  verdict_t    expected_q [$];

  function automatic logic [31:0] len_mask(logic [5:0] len);
    return (len == 0) ? 32'h0 : (32'hffff_ffff << (32 - len));
  endfunction

  // Updates the model tables and counters and returns the outcome of one transaction.
  function automatic verdict_t mark_transaction();
    verdict_t    v;
    logic [1:0]  m;
    logic [31:0] key, c;
    logic [5:0]  best_len;
    logic [7:0]  best_mark;
    logic        hit;
    v = '0;
    hit = 0;
    best_len = 0;
    best_mark = 0;
    case (dscpm_pkg::opcode_t'(opcode))
      dscpm_pkg::OP_WRITE: begin
        if (index < ENTRIES && prefix_len <= 32) begin
          routes[index].valid = 1;
          routes[index].plen  = prefix_len;
          routes[index].addr  = dst_addr & len_mask(prefix_len);
          routes[index].mark  = write_value;
        end
        return v;
      end
      dscpm_pkg::OP_REMOVE: begin
        if (index < ENTRIES) routes[index].valid = 0;
        return v;
      end
      dscpm_pkg::OP_MODE: begin
        if (index < INTERFACES) if_mode[index] = (write_value > 3) ? 2'd3 : write_value[1:0];
        return v;
      end
      default: ;
    endcase
    v.new_tos = tos;
    v.new_checksum = checksum;
    // Runt frames are dropped and counted.
    if (frame_len < dscpm_pkg::MIN_FRAME_LEN) begin
      pkt_cnt[1] += 1;
      byt_cnt[1] += frame_len;
      v.action = 1;
      v.recorded = 1;
      v.packet_total = pkt_cnt[1];
      v.byte_total = byt_cnt[1];
      return v;
    end
    if (ttl <= 1 || ethertype != dscpm_pkg::ETHERTYPE_IPV4) return v;
    m = (index < INTERFACES) ? if_mode[index] : 2'd0;
    if (m == 0) return v;
    pkt_cnt[0] += 1;
    byt_cnt[0] += frame_len;
    v.recorded = 1;
    v.packet_total = pkt_cnt[0];
    v.byte_total = byt_cnt[0];
    if (!fib_ok || m == 3) return v;
    // Longest valid match; ties keep the lowest slot.
    key = (m == 1) ? dst_addr : src_addr;
    for (int i = 0; i < ENTRIES; i++) begin
      if (routes[i].valid && (key & len_mask(routes[i].plen)) == routes[i].addr &&
          (!hit || routes[i].plen > best_len)) begin
        hit = 1;
        best_len = routes[i].plen;
        best_mark = routes[i].mark;
      end
    end
    if (hit) begin
      c = checksum + tos;
      if (((c + 1) >> 16) != 0) c = (c + 1) & 32'hffff;
      c = c - best_mark;
      c = c + (c >> 16);
      v.marked = 1;
      v.new_tos = best_mark;
      v.new_checksum = c[15:0];
    end
    return v;
  endfunction

  // Prediction on input transactions, comparison on output transactions.
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) routes[i].valid = 0;
      for (int i = 0; i < INTERFACES; i++) if_mode[i] = 0;
      pkt_cnt = '{0, 0};
      byt_cnt = '{0, 0};
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(mark_transaction());
      if (out_valid && !out_stall) begin
        got = '{action, recorded, marked, new_tos, new_checksum, packet_total, byte_total};
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.action !== want.action) begin
            $error("action: expected %0h, got %0h", want.action, got.action);
            fail_count++;
          end
          if (got.recorded !== want.recorded) begin
            $error("recorded: expected %0h, got %0h", want.recorded, got.recorded);
            fail_count++;
          end
          if (got.marked !== want.marked) begin
            $error("marked: expected %0h, got %0h", want.marked, got.marked);
            fail_count++;
          end
          if (got.new_tos !== want.new_tos) begin
            $error("new_tos: expected %0h, got %0h", want.new_tos, got.new_tos);
            fail_count++;
          end
          if (got.new_checksum !== want.new_checksum) begin
            $error("new_checksum: expected %0h, got %0h",
                   want.new_checksum, got.new_checksum);
            fail_count++;
          end
          if (got.packet_total !== want.packet_total) begin
            $error("packet_total: expected %0h, got %0h",
                   want.packet_total, got.packet_total);
            fail_count++;
          end
          if (got.byte_total !== want.byte_total) begin
            $error("byte_total: expected %0h, got %0h", want.byte_total, got.byte_total);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/tb_ipv4_dscp_marker_lpm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSCP marker testbench
// Directed table setup and edge-case packets, then random packets and table
// writes under three idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_ipv4_dscp_marker_lpm;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  opcode = dscpm_pkg::OP_PACKET;
  logic [6:0]  index = 0;
  logic [15:0] frame_len = 0;
  logic [15:0] ethertype = 0;
  logic [7:0]  ttl = 0;
  logic [7:0]  tos = 0;
  logic [15:0] checksum = 0;
  logic [31:0] src_addr = 0;
  logic [31:0] dst_addr = 0;
  logic        fib_ok = 0;
  logic [5:0]  prefix_len = 0;
  logic [7:0]  write_value = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        action, recorded, marked;
  logic [7:0]  new_tos;
  logic [15:0] new_checksum;
  logic [63:0] packet_total, byte_total;
  int          fail_count, pending;
  int          send_idle = 0, recv_idle = 0;
  logic [31:0] prefixes [8];

  always #5 clk = ~clk;

  ipv4_dscp_marker_lpm dut (.*);
  dscpm_checker chk (.*);

  // Receiver stall at the configured rate.
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  // Presents one transaction and holds it until accepted. Valid stays high
  // after acceptance until the next transaction or an idle cycle replaces it.
  task automatic send_item(logic [31:0] op, logic [31:0] idx, logic [31:0] flen,
                           logic [31:0] etype, logic [31:0] t, logic [31:0] ts,
                           logic [31:0] cs, logic [31:0] sa, logic [31:0] da,
                           logic [31:0] fib, logic [31:0] pl, logic [31:0] wv);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= 2'(op);
    index       <= 7'(idx);
    frame_len   <= 16'(flen);
    ethertype   <= 16'(etype);
    ttl         <= 8'(t);
    tos         <= 8'(ts);
    checksum    <= 16'(cs);
    src_addr    <= sa;
    dst_addr    <= da;
    fib_ok      <= fib[0];
    prefix_len  <= 6'(pl);
    write_value <= 8'(wv);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A header near one of the loaded prefixes so that lookups hit often.
  task automatic random_item();
    int r;
    logic [31:0] a, b;
    r = $urandom_range(99);
    a = ($urandom_range(3) != 0)
        ? prefixes[$urandom_range(7)] ^ ($urandom >> $urandom_range(31, 8)) : $urandom;
    b = ($urandom_range(3) != 0)
        ? prefixes[$urandom_range(7)] ^ ($urandom >> $urandom_range(31, 8)) : $urandom;
    if (r < 8)
      send_item(dscpm_pkg::OP_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, prefixes[$urandom_range(7)] ^ ($urandom >> 12),
                $urandom, ($urandom_range(9) == 0) ? $urandom : $urandom_range(32),
                $urandom);
    else if (r < 11)
      send_item(dscpm_pkg::OP_REMOVE, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (r < 14)
      send_item(dscpm_pkg::OP_MODE, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom,
                ($urandom_range(3) == 0) ? $urandom : $urandom_range(3));
    else if (r < 80)
      send_item(dscpm_pkg::OP_PACKET, $urandom_range(70), $urandom_range(1500, 34),
                16'h0800, $urandom_range(255, 2), $urandom, $urandom, a, b,
                $urandom_range(7) != 0, $urandom, $urandom);
    else
      send_item(dscpm_pkg::OP_PACKET, $urandom,
                ($urandom_range(1) != 0) ? $urandom_range(40) : $urandom,
                ($urandom_range(1) != 0) ? 32'h0800 : $urandom, $urandom_range(3),
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) prefixes[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: modes, extremes of the tables and the special cases.
    send_item(dscpm_pkg::OP_MODE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_item(dscpm_pkg::OP_MODE, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2);
    send_item(dscpm_pkg::OP_MODE, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hff);
    send_item(dscpm_pkg::OP_MODE, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_item(dscpm_pkg::OP_MODE, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2);
    send_item(dscpm_pkg::OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, 0, 0, 8'h11);
    send_item(dscpm_pkg::OP_WRITE, 5, 0, 0, 0, 0, 0, 0, 32'h0a01_02ff, 0, 24, 8'hfc);
    send_item(dscpm_pkg::OP_WRITE, 3, 0, 0, 0, 0, 0, 0, 32'h0a01_0203, 0, 24, 8'h22);
    send_item(dscpm_pkg::OP_WRITE, 127, 0, 0, 0, 0, 0, 0, 32'hffff_ffff, 0, 32, 8'hff);
    send_item(dscpm_pkg::OP_WRITE, 9, 0, 0, 0, 0, 0, 0, 32'h0a00_0000, 0, 33, 8'h33);
    send_item(dscpm_pkg::OP_PACKET, 1, 0, 16'h0800, 64, 0, 0, 0, 0, 1, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 1, 13, 16'h0800, 64, 0, 0, 0, 0, 1, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 1, 33, 16'h0800, 64, 0, 0, 0, 0, 1, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 1, 16'hffff, 16'h0800, 1, 0, 0, 0, 0, 1, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 1, 34, 16'h86dd, 64, 0, 0, 0, 0, 1, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 0, 34, 16'h0800, 64, 0, 0, 0, 0, 1, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 1, 60, 16'h0800, 255, 8'hff, 16'hffff, 0,
              32'h0a01_0209, 1, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 1, 60, 16'h0800, 2, 8'h00, 16'h0000, 0,
              32'hffff_ffff, 1, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 2, 60, 16'h0800, 64, 8'h10, 16'h1234,
              32'h0a01_0207, 0, 1, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 1, 60, 16'h0800, 64, 8'h10, 16'h1234, 0,
              32'h0a01_0207, 0, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 3, 60, 16'h0800, 64, 8'h10, 16'h1234, 0, 0, 1, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 127, 60, 16'h0800, 64, 8'h10, 16'h1234, 0, 0, 1, 0, 0);
    send_item(dscpm_pkg::OP_REMOVE, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(dscpm_pkg::OP_REMOVE, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(dscpm_pkg::OP_PACKET, 1, 60, 16'h0800, 64, 8'h10, 16'h1234, 0,
              32'h0a01_0207, 1, 0, 0);

    // Hold off until the block has drained.
    drain();

    // Load some prefixes and modes for the random part.
    for (int i = 0; i < 40; i++)
      send_item(dscpm_pkg::OP_WRITE, $urandom, 0, 0, 0, 0, 0, 0,
                prefixes[i % 8] ^ ($urandom >> 16), 0, $urandom_range(32), $urandom);
    for (int i = 0; i < 64; i++)
      send_item(dscpm_pkg::OP_MODE, i, 0, 0, 0, 0, 0, 0, 0, 0, 0, $urandom_range(3));

    send_idle = 35; recv_idle = 82;
    repeat (330) random_item();
    send_idle = 82; recv_idle = 35;
    repeat (330) random_item();
    send_idle = 0; recv_idle = 0;
    repeat (340) random_item();

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("tb_ipv4_dscp_marker_lpm: done, clean");
    else
      $display("tb_ipv4_dscp_marker_lpm: done, errors");
    $finish;
  end

  // Watchdog well above the slowest correct run.
  initial begin
    #20ms;
    $display("tb_ipv4_dscp_marker_lpm: done, errors");
    $finish;
  end

endmodule
